// ===== hw/rtl/ppc_pkg.sv =====
package ppc_pkg;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_X     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_Y     = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_Z     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_PLANE_OFFSET = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_RESTITUTION  = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_FRICTION     = 3'd5;

	// fixed point
	localparam int FRAC = 14;
	localparam logic [14:0] ONE_Q14 = 15'd16384;

	// reset values
	localparam logic signed [15:0] RST_NORMAL_X     = 16'sd0;
	localparam logic signed [15:0] RST_NORMAL_Y     = 16'sd16384;
	localparam logic signed [15:0] RST_NORMAL_Z     = 16'sd0;
	localparam logic signed [31:0] RST_PLANE_OFFSET = -32'sd65536;
	localparam logic [15:0]        RST_RESTITUTION  = 16'd16384;
	localparam logic [14:0]        RST_FRICTION     = 15'd4915;

	// datapath widths, all lossless
	localparam int NP_W   = 48;	// normal times position or velocity
	localparam int NPS_W  = 50;	// sum of three such products
	localparam int D_W    = 37;	// signed distance
	localparam int VN_W   = 36;	// velocity along the normal
	localparam int ND_W   = 53;	// normal times distance
	localparam int NVN_W  = 52;	// normal times vn
	localparam int POS_W  = 40;	// corrected position
	localparam int R_W    = 40;	// reflected velocity
	localparam int NR_W   = 56;	// normal times reflected velocity
	localparam int NRS_W  = 58;	// sum of three such products
	localparam int RDOT_W = 44;	// reflected velocity along the normal
	localparam int NRD_W  = 60;	// normal times rdot
	localparam int RN_W   = 46;	// normal part
	localparam int RT_W   = 47;	// tangent part
	localparam int PR_W   = 63;	// scaled parts before shift
	localparam int NV_W   = 50;	// new velocity before clamp

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} ppc_in_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
		logic               collided;
	} ppc_out_t;

	// settings as the datapath sees them
	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [31:0] plane_offset;
		logic [15:0]        restitution;
		logic [14:0]        keep;		// one minus friction, floored at zero
	} ppc_cfg_t;

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [NV_W-1:0] x);
		logic [NV_W-32:0] top;
		top = x[NV_W-1:31];
		if ((&top) || !(|top)) begin
			return x[31:0];
		end else if (x[NV_W-1]) begin
			return 32'sh8000_0000;
		end else begin
			return 32'sh7fff_ffff;
		end
	endfunction

endpackage

// ===== hw/rtl/particle_plane_collision.sv =====
// A particle taken with start passes stages s1 to s10 and gives its result on done.
// Throughput: one particle per cycle; busy stays low and the ten-stage multiply
// pipeline takes a new beat every cycle.
// The receiver cannot stall: each result is shown for one cycle only.
// Reset clears the pipeline valid bits and returns all settings to their defaults.
module particle_plane_collision (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  ppc_pkg::ppc_in_t               particle,
	output logic                           done,
	output ppc_pkg::ppc_out_t              result,
	input  logic                           cfg_we,
	input  logic [ppc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data
);

	ppc_pkg::ppc_cfg_t cfg;

	ppc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	logic accept;
	logic signed [15:0] n [3];
	logic signed [31:0] p_in [3];
	logic signed [31:0] v_in [3];
	logic signed [16:0] rest_c;
	logic signed [15:0] keep_c;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign n[0] = cfg.normal_x;
	assign n[1] = cfg.normal_y;
	assign n[2] = cfg.normal_z;
	assign p_in[0] = particle.pos_x;
	assign p_in[1] = particle.pos_y;
	assign p_in[2] = particle.pos_z;
	assign v_in[0] = particle.vel_x;
	assign v_in[1] = particle.vel_y;
	assign v_in[2] = particle.vel_z;
	assign rest_c = signed'({1'b0, cfg.restitution});
	assign keep_c = signed'({1'b0, cfg.keep});

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	// payload stages
	logic signed [ppc_pkg::NP_W-1:0]   np_s1 [3];
	logic signed [ppc_pkg::NP_W-1:0]   nv_s1 [3];
	logic signed [31:0]                p_s1 [3], p_s2 [3], p_s3 [3];
	logic signed [31:0]                v_s1 [3], v_s2 [3], v_s3 [3], v_s4 [3], v_s5 [3];
	logic signed [31:0]                v_s6 [3], v_s7 [3], v_s8 [3], v_s9 [3];
	logic signed [ppc_pkg::D_W-1:0]    d_s2;
	logic signed [ppc_pkg::VN_W-1:0]   vn_s2;
	logic                              coll_s2, coll_s3, coll_s4, coll_s5, coll_s6;
	logic                              coll_s7, coll_s8, coll_s9;
	logic signed [ppc_pkg::ND_W-1:0]   nd_s3 [3];
	logic signed [ppc_pkg::NVN_W-1:0]  nvn_s3 [3];
	logic signed [ppc_pkg::POS_W-1:0]  pos_s4 [3], pos_s5 [3], pos_s6 [3], pos_s7 [3];
	logic signed [ppc_pkg::POS_W-1:0]  pos_s8 [3], pos_s9 [3];
	logic signed [ppc_pkg::R_W-1:0]    r_s4 [3], r_s5 [3], r_s6 [3], r_s7 [3];
	logic signed [ppc_pkg::NR_W-1:0]   nr_s5 [3];
	logic signed [ppc_pkg::RDOT_W-1:0] rdot_s6;
	logic signed [ppc_pkg::NRD_W-1:0]  nrd_s7 [3];
	logic signed [ppc_pkg::RN_W-1:0]   rn_s8 [3];
	logic signed [ppc_pkg::RT_W-1:0]   rt_s8 [3];
	logic signed [ppc_pkg::PR_W-1:0]   prn_s9 [3], prt_s9 [3];
	ppc_pkg::ppc_out_t                 res_s10;

	// combinational results of each stage
	logic signed [ppc_pkg::NPS_W-1:0]  np_sum, nv_sum;
	logic signed [ppc_pkg::D_W-1:0]    d_c;
	logic signed [ppc_pkg::NRS_W-1:0]  nr_sum;
	logic signed [ppc_pkg::RN_W-1:0]   rn_c [3];
	logic signed [ppc_pkg::NV_W-1:0]   nv_c [3];
	logic signed [31:0]                pos_o [3], vel_o [3];

	// distance and velocity along the normal, and the reflected velocity projection sum
	always_comb begin
		np_sum = ppc_pkg::NPS_W'(np_s1[0]) + ppc_pkg::NPS_W'(np_s1[1])
			+ ppc_pkg::NPS_W'(np_s1[2]);
		nv_sum = ppc_pkg::NPS_W'(nv_s1[0]) + ppc_pkg::NPS_W'(nv_s1[1])
			+ ppc_pkg::NPS_W'(nv_s1[2]);
		d_c = ppc_pkg::D_W'(np_sum >>> ppc_pkg::FRAC) - ppc_pkg::D_W'(cfg.plane_offset);
		nr_sum = ppc_pkg::NRS_W'(nr_s5[0]) + ppc_pkg::NRS_W'(nr_s5[1])
			+ ppc_pkg::NRS_W'(nr_s5[2]);
	end

	// split, scale and clamp per axis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rn_c[i] = ppc_pkg::RN_W'(nrd_s7[i] >>> ppc_pkg::FRAC);
			nv_c[i] = ppc_pkg::NV_W'(prn_s9[i] >>> ppc_pkg::FRAC)
				+ ppc_pkg::NV_W'(prt_s9[i] >>> ppc_pkg::FRAC);
			pos_o[i] = ppc_pkg::sat32(ppc_pkg::NV_W'(pos_s9[i]));
			vel_o[i] = coll_s9 ? ppc_pkg::sat32(nv_c[i]) : v_s9[i];
		end
	end

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	// advance the payload; every stage moves each cycle
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			// stage 1: project position and velocity on the normal
			np_s1[i] <= ppc_pkg::NP_W'(n[i]) * ppc_pkg::NP_W'(p_in[i]);
			nv_s1[i] <= ppc_pkg::NP_W'(n[i]) * ppc_pkg::NP_W'(v_in[i]);
			p_s1[i]  <= p_in[i];
			v_s1[i]  <= v_in[i];

			// stage 2: carry
			p_s2[i] <= p_s1[i];
			v_s2[i] <= v_s1[i];

			// stage 3: scale the normal by distance and by vn
			nd_s3[i]  <= ppc_pkg::ND_W'(n[i]) * ppc_pkg::ND_W'(d_s2);
			nvn_s3[i] <= ppc_pkg::NVN_W'(n[i]) * ppc_pkg::NVN_W'(vn_s2);
			p_s3[i]   <= p_s2[i];
			v_s3[i]   <= v_s2[i];

			// stage 4: push back onto the plane and reflect
			if (coll_s3) begin
				pos_s4[i] <= ppc_pkg::POS_W'(p_s3[i])
					- ppc_pkg::POS_W'(nd_s3[i] >>> ppc_pkg::FRAC);
			end else begin
				pos_s4[i] <= ppc_pkg::POS_W'(p_s3[i]);
			end
			r_s4[i] <= ppc_pkg::R_W'(v_s3[i])
				- (ppc_pkg::R_W'(nvn_s3[i] >>> ppc_pkg::FRAC) <<< 1);
			v_s4[i] <= v_s3[i];

			// stage 5: project the reflected velocity
			nr_s5[i]  <= ppc_pkg::NR_W'(n[i]) * ppc_pkg::NR_W'(r_s4[i]);
			r_s5[i]   <= r_s4[i];
			pos_s5[i] <= pos_s4[i];
			v_s5[i]   <= v_s4[i];

			// stage 6: carry
			r_s6[i]   <= r_s5[i];
			pos_s6[i] <= pos_s5[i];
			v_s6[i]   <= v_s5[i];

			// stage 7: normal part before shift
			nrd_s7[i] <= ppc_pkg::NRD_W'(n[i]) * ppc_pkg::NRD_W'(rdot_s6);
			r_s7[i]   <= r_s6[i];
			pos_s7[i] <= pos_s6[i];
			v_s7[i]   <= v_s6[i];

			// stage 8: normal and tangent parts
			rn_s8[i]  <= rn_c[i];
			rt_s8[i]  <= ppc_pkg::RT_W'(r_s7[i]) - ppc_pkg::RT_W'(rn_c[i]);
			pos_s8[i] <= pos_s7[i];
			v_s8[i]   <= v_s7[i];

			// stage 9: restitution and friction
			prn_s9[i] <= ppc_pkg::PR_W'(rn_s8[i]) * ppc_pkg::PR_W'(rest_c);
			prt_s9[i] <= ppc_pkg::PR_W'(rt_s8[i]) * ppc_pkg::PR_W'(keep_c);
			pos_s9[i] <= pos_s8[i];
			v_s9[i]   <= v_s8[i];
		end

		// stage 2: sums, shift and compare
		d_s2    <= d_c;
		vn_s2   <= ppc_pkg::VN_W'(nv_sum >>> ppc_pkg::FRAC);
		coll_s2 <= d_c < 0;

		coll_s3 <= coll_s2;
		coll_s4 <= coll_s3;
		coll_s5 <= coll_s4;

		// stage 6: reflected velocity along the normal
		rdot_s6 <= ppc_pkg::RDOT_W'(nr_sum >>> ppc_pkg::FRAC);
		coll_s6 <= coll_s5;
		coll_s7 <= coll_s6;
		coll_s8 <= coll_s7;
		coll_s9 <= coll_s8;

		// stage 10: clamp into the output register
		res_s10.new_pos_x <= pos_o[0];
		res_s10.new_pos_y <= pos_o[1];
		res_s10.new_pos_z <= pos_o[2];
		res_s10.new_vel_x <= vel_o[0];
		res_s10.new_vel_y <= vel_o[1];
		res_s10.new_vel_z <= vel_o[2];
		res_s10.collided  <= coll_s9;
	end

	assign done   = vld_s10;
	assign result = res_s10;

endmodule

// ===== hw/rtl/ppc_regs.sv =====
module ppc_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ppc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [ppc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output ppc_pkg::ppc_cfg_t                cfg
);

	logic signed [15:0] normal_x_q;
	logic signed [15:0] normal_y_q;
	logic signed [15:0] normal_z_q;
	logic signed [31:0] plane_offset_q;
	logic [15:0]        restitution_q;
	logic [14:0]        friction_q;

	// take a register write; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_x_q     <= ppc_pkg::RST_NORMAL_X;
			normal_y_q     <= ppc_pkg::RST_NORMAL_Y;
			normal_z_q     <= ppc_pkg::RST_NORMAL_Z;
			plane_offset_q <= ppc_pkg::RST_PLANE_OFFSET;
			restitution_q  <= ppc_pkg::RST_RESTITUTION;
			friction_q     <= ppc_pkg::RST_FRICTION;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ppc_pkg::REG_NORMAL_X:     normal_x_q     <= cfg_data[15:0];
				ppc_pkg::REG_NORMAL_Y:     normal_y_q     <= cfg_data[15:0];
				ppc_pkg::REG_NORMAL_Z:     normal_z_q     <= cfg_data[15:0];
				ppc_pkg::REG_PLANE_OFFSET: plane_offset_q <= cfg_data[31:0];
				ppc_pkg::REG_RESTITUTION:  restitution_q  <= cfg_data[15:0];
				ppc_pkg::REG_FRICTION:     friction_q     <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// friction above one keeps nothing of the tangent part
	always_comb begin
		cfg.normal_x     = normal_x_q;
		cfg.normal_y     = normal_y_q;
		cfg.normal_z     = normal_z_q;
		cfg.plane_offset = plane_offset_q;
		cfg.restitution  = restitution_q;
		if (friction_q > ppc_pkg::ONE_Q14) begin
			cfg.keep = '0;
		end else begin
			cfg.keep = ppc_pkg::ONE_Q14 - friction_q;
		end
	end

endmodule

// ===== hw/rtl/ppc_checker.sv =====
module ppc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input ppc_pkg::ppc_in_t  particle,
	input logic              done,
	input ppc_pkg::ppc_out_t result
);

	// every accepted beat comes out on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##10 done)
		else $error("accepted beat did not complete after ten cycles");

	// no result appears without an accepted beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##10 !done)
		else $error("result without an accepted beat");

	// the pipeline never holds the sender off
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// a particle on or above the plane keeps its x position and y velocity
	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.collided) |->
			(result.new_pos_x == $past(particle.pos_x, 10))
			&& (result.new_vel_y == $past(particle.vel_y, 10)))
		else $error("pass-through particle altered");

endmodule

bind particle_plane_collision ppc_checker u_ppc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.particle (particle),
	.done     (done),
	.result   (result)
);

// ===== tb/particle_plane_collision_test.sv =====
module particle_plane_collision_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ppc_pkg::*;

	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	// indexes past the last register, writes to them must be dropped
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int PIPE_DEPTH      = 10;
	localparam int ITEMS_PER_PHASE = 56;
	localparam int RANDOM_PHASES   = 8;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic signed [31:0] offset;
		logic [15:0]        restitution;
		logic [14:0]        friction;
	} plane_settings_t;

	class bounce_scoreboard;
		plane_settings_t regs;
		ppc_out_t        predicted[$];
		int              errors;

		function new();
			regs.nx          = RST_NORMAL_X;
			regs.ny          = RST_NORMAL_Y;
			regs.nz          = RST_NORMAL_Z;
			regs.offset      = RST_PLANE_OFFSET;
			regs.restitution = RST_RESTITUTION;
			regs.friction    = RST_FRICTION;
			errors           = 0;
		endfunction

		static function logic [31:0] clamp32(input longint x);
			if (x > S32_MAX) begin
				return Q_MAX;
			end else if (x < S32_MIN) begin
				return Q_MIN;
			end
			return 32'(x);
		endfunction

		// mirror a register write, ignoring indexes with no register behind them
		function void set_register(input logic [CFG_ADDR_W-1:0] addr,
				input logic [CFG_DATA_W-1:0] data);
			case (addr)
				REG_NORMAL_X:     regs.nx = data[15:0];
				REG_NORMAL_Y:     regs.ny = data[15:0];
				REG_NORMAL_Z:     regs.nz = data[15:0];
				REG_PLANE_OFFSET: regs.offset = data;
				REG_RESTITUTION:  regs.restitution = data[15:0];
				REG_FRICTION:     regs.friction = data[14:0];
				default: ;
			endcase
		endfunction

		// work out the bounced particle at full width, clamping only at the end
		function ppc_out_t predict_response(input ppc_in_t p);
			longint   n[3];
			longint   q[3];
			longint   v[3];
			longint   r[3];
			longint   np[3];
			longint   nv[3];
			longint   plane_dist;
			longint   vn;
			longint   rdot;
			longint   keep;
			longint   rn;
			longint   rt;
			longint   rest;
			ppc_out_t o;
			int       i;

			n[0] = longint'($signed(regs.nx));
			n[1] = longint'($signed(regs.ny));
			n[2] = longint'($signed(regs.nz));
			q[0] = longint'($signed(p.pos_x));
			q[1] = longint'($signed(p.pos_y));
			q[2] = longint'($signed(p.pos_z));
			v[0] = longint'($signed(p.vel_x));
			v[1] = longint'($signed(p.vel_y));
			v[2] = longint'($signed(p.vel_z));
			rest = longint'(regs.restitution);

			plane_dist = ((n[0] * q[0] + n[1] * q[1] + n[2] * q[2]) >>> FRAC)
				- longint'($signed(regs.offset));

			if (plane_dist >= 0) begin
				// on or above the plane: pass through untouched
				np = q;
				nv = v;
				o.collided = 1'b0;
			end else begin
				// friction of one or more wipes out the tangent part
				keep = (regs.friction > ONE_Q14) ? 64'sd0
					: longint'(ONE_Q14) - longint'(regs.friction);
				vn = (n[0] * v[0] + n[1] * v[1] + n[2] * v[2]) >>> FRAC;
				for (i = 0; i < 3; i++) begin
					r[i] = v[i] - 2 * ((n[i] * vn) >>> FRAC);
				end
				rdot = (n[0] * r[0] + n[1] * r[1] + n[2] * r[2]) >>> FRAC;
				for (i = 0; i < 3; i++) begin
					rn = (n[i] * rdot) >>> FRAC;
					rt = r[i] - rn;
					nv[i] = ((rn * rest) >>> FRAC) + ((rt * keep) >>> FRAC);
					np[i] = q[i] - ((n[i] * plane_dist) >>> FRAC);
				end
				o.collided = 1'b1;
			end

			o.new_pos_x = clamp32(np[0]);
			o.new_pos_y = clamp32(np[1]);
			o.new_pos_z = clamp32(np[2]);
			o.new_vel_x = clamp32(nv[0]);
			o.new_vel_y = clamp32(nv[1]);
			o.new_vel_z = clamp32(nv[2]);
			return o;
		endfunction

		function void note_particle(input ppc_in_t p);
			predicted.push_back(predict_response(p));
		endfunction

		function int outstanding();
			return predicted.size();
		endfunction

		function void compare_field(input string name, input logic [31:0] want,
				input logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %h actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		// compare one result beat against the oldest prediction
		function void check_response(input ppc_out_t got);
			ppc_out_t want;
			if (predicted.size() == 0) begin
				$display("%0t: result with no particle outstanding, expected none actual %h",
					$time, got);
				errors++;
				return;
			end
			want = predicted.pop_front();
			compare_field("new_pos_x", want.new_pos_x, got.new_pos_x);
			compare_field("new_pos_y", want.new_pos_y, got.new_pos_y);
			compare_field("new_pos_z", want.new_pos_z, got.new_pos_z);
			compare_field("new_vel_x", want.new_vel_x, got.new_vel_x);
			compare_field("new_vel_y", want.new_vel_y, got.new_vel_y);
			compare_field("new_vel_z", want.new_vel_z, got.new_vel_z);
			compare_field("collided", 32'(want.collided), 32'(got.collided));
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  start    = 1'b0;
	logic                  busy;
	ppc_in_t               particle = '0;
	logic                  done;
	ppc_out_t              result;
	logic                  cfg_we   = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bounce_scoreboard board = new();
	int               idle_pct = 0;

	particle_plane_collision dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.particle (particle),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// check every result beat on the edge that ends its cycle
	always @(posedge clk) begin
		if (arst_n && done) begin
			board.check_response(result);
		end
	end

	// give up on a hung run
	initial begin
		#200us;
		$display("status: fail");
		$finish;
	end

	function automatic ppc_in_t particle_of(input logic [31:0] px, py, pz, vx, vy, vz);
		ppc_in_t p;
		p.pos_x = px;
		p.pos_y = py;
		p.pos_z = pz;
		p.vel_x = vx;
		p.vel_y = vy;
		p.vel_z = vz;
		return p;
	endfunction

	function automatic plane_settings_t settings_of(input logic [15:0] nx, ny, nz,
			input logic [31:0] off, input logic [15:0] rest, input logic [14:0] fric);
		plane_settings_t s;
		s.nx          = nx;
		s.ny          = ny;
		s.nz          = nz;
		s.offset      = off;
		s.restitution = rest;
		s.friction    = fric;
		return s;
	endfunction

	function automatic logic [31:0] rand_extreme();
		case ($urandom_range(4))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return '0;
			3: return '1;
			default: return Q_ONE;
		endcase
	endfunction

	function automatic logic [31:0] rand_velocity();
		logic signed [31:0] t;
		case ($urandom_range(3))
			0: return $urandom;
			1: return rand_extreme();
			default: begin
				t = $urandom;
				return t >>> $urandom_range(8, 24);
			end
		endcase
	endfunction

	// mostly particles close to the plane so both sides get hit, the rest wild
	function automatic ppc_in_t make_particle(input plane_settings_t s);
		longint             nrm[3];
		logic [31:0]        pos[3];
		logic [31:0]        vel[3];
		logic signed [31:0] jit;
		int                 kind;
		int                 i;

		nrm[0] = longint'($signed(s.nx));
		nrm[1] = longint'($signed(s.ny));
		nrm[2] = longint'($signed(s.nz));
		kind = $urandom_range(9);
		for (i = 0; i < 3; i++) begin
			case (kind)
				0, 1: begin
					pos[i] = $urandom;
					vel[i] = $urandom;
				end
				8: begin
					pos[i] = rand_extreme();
					vel[i] = rand_extreme();
				end
				default: begin
					jit = $urandom;
					jit = jit >>> $urandom_range(6, 28);
					pos[i] = bounce_scoreboard::clamp32(
						((nrm[i] * longint'($signed(s.offset))) >>> FRAC) + longint'(jit));
					vel[i] = (kind == 9) ? rand_extreme() : rand_velocity();
				end
			endcase
		end
		return particle_of(pos[0], pos[1], pos[2], vel[0], vel[1], vel[2]);
	endfunction

	task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		@(posedge clk);
		board.set_register(addr, data);
	endtask

	// write every register, junk in the unused upper bits, then poke the spare indexes
	task automatic apply_settings(input plane_settings_t s);
		write_register(REG_NORMAL_X, {16'($urandom), s.nx});
		write_register(REG_NORMAL_Y, {16'($urandom), s.ny});
		write_register(REG_NORMAL_Z, {16'($urandom), s.nz});
		write_register(REG_PLANE_OFFSET, s.offset);
		write_register(REG_RESTITUTION, {16'($urandom), s.restitution});
		write_register(REG_FRICTION, {17'($urandom), s.friction});
		write_register(REG_SPARE_LO, $urandom);
		write_register(REG_SPARE_HI, $urandom);
		cfg_we <= 1'b0;
	endtask

	task automatic idle_cycle();
		start    <= 1'b0;
		particle <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		@(posedge clk);
	endtask

	// hold start until the beat is taken, with random gaps ahead of it
	task automatic send_particle(input ppc_in_t p);
		while ($urandom_range(99) < idle_pct) begin
			idle_cycle();
		end
		start    <= 1'b1;
		particle <= p;
		do begin
			@(posedge clk);
		end while (busy);
		board.note_particle(p);
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		while (board.outstanding() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic run_directed();
		// reset defaults: floor one unit below the origin
		send_particle(particle_of('0, '0, '0, '0, '0, '0));
		send_particle(particle_of(Q_ONE, -Q_ONE, Q_ONE, Q_ONE, -Q_ONE, '0));
		send_particle(particle_of('0, -Q_ONE - 1, '0, 3 * Q_ONE, -2 * Q_ONE, Q_ONE));
		send_particle(particle_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_particle(particle_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		send_particle(particle_of('1, '1, '1, '1, '1, '1));
		send_particle(particle_of(Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN));
		send_particle(particle_of(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
			32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa));
		send_particle(particle_of(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
			32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555));

		// flipped x normal, offset and bounce at their top, no friction
		wait_for_results();
		apply_settings(settings_of(-16'sd16384, 16'sd0, 16'sd0, Q_MAX, 16'hffff, 15'd0));
		send_particle(particle_of(Q_MIN, '0, '0, Q_ONE, Q_ONE, Q_ONE));
		send_particle(particle_of(Q_MIN + 1, '0, '0, Q_ONE, Q_ONE, Q_ONE));
		send_particle(particle_of(Q_MIN + 2, '0, '0, Q_MAX, Q_MIN, Q_MAX));
		send_particle(particle_of('0, '0, '0, Q_MAX, Q_MAX, Q_MAX));

		// friction above one drops the tangent part
		wait_for_results();
		apply_settings(settings_of(16'sd0, 16'sd0, 16'sd16384, '0, 16'd0, 15'h7fff));
		send_particle(particle_of(Q_ONE, Q_ONE, '1, Q_MAX, Q_MIN, Q_ONE));
		wait_for_results();
		apply_settings(settings_of(16'sd0, 16'sd0, 16'sd16384, '0, 16'd16384, 15'd16385));
		send_particle(particle_of(Q_ONE, Q_ONE, '1, Q_MAX, Q_MIN, Q_ONE));
		send_particle(particle_of(Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN));

		// normal far from unit length, applied as it stands
		wait_for_results();
		apply_settings(settings_of(16'h8000, 16'h7fff, 16'h8000, Q_MIN, 16'hffff, 15'd16384));
		send_particle(particle_of(Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX));
		send_particle(particle_of(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
		send_particle(particle_of(32'd1, 32'd1, 32'd1, '1, '1, '1));
	endtask

	function automatic plane_settings_t phase_settings(input int ph);
		case (ph)
			0: return settings_of(RST_NORMAL_X, RST_NORMAL_Y, RST_NORMAL_Z,
				RST_PLANE_OFFSET, RST_RESTITUTION, RST_FRICTION);
			1: return settings_of(16'sd16384, 16'sd0, 16'sd0, '0, 16'd0, 15'd0);
			2: return settings_of(16'sd0, 16'sd0, -16'sd16384, Q_MIN, 16'hffff, 15'd16384);
			3: return settings_of(16'sd0, 16'sd0, 16'sd16384, Q_MAX, 16'hffff, 15'h7fff);
			4: return settings_of(16'sd11585, 16'sd11585, 16'sd0, $urandom >> 8,
				16'd16384, 15'd8192);
			5: return settings_of(16'sd9459, -16'sd9459, 16'sd9459, Q_ONE,
				16'd12000, 15'd20000);
			6: return settings_of(16'($urandom_range(32768) - 16384),
				16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
				$urandom, 16'($urandom), 15'($urandom_range(16384)));
			default: return settings_of(16'($urandom), 16'($urandom), 16'($urandom),
				$urandom, 16'($urandom), 15'($urandom));
		endcase
	endfunction

	// drain, reprogram, then stream random particles at one idle level
	task automatic run_phase(input plane_settings_t s, input int pct);
		int k;
		wait_for_results();
		apply_settings(s);
		idle_pct = pct;
		for (k = 0; k < ITEMS_PER_PHASE; k++) begin
			if (k == ITEMS_PER_PHASE / 2 || $urandom_range(99) < 2) begin
				wait_for_results();
			end
			send_particle(make_particle(s));
		end
	endtask

	initial begin
		int ph;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 0;
		run_directed();
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			run_phase(phase_settings(ph), (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 73 : 28);
		end

		// let the pipeline empty and catch any stray beats
		wait_for_results();
		repeat (PIPE_DEPTH + 2) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
